// ===== sv/zero_crossing_pitch_detector_top_macros.svh =====
// Assertion macros for the pitch detector. Both expect clk and rst_n in scope.
`ifndef ZERO_CROSSING_PITCH_DETECTOR_TOP_MACROS_SVH
`define ZERO_CROSSING_PITCH_DETECTOR_TOP_MACROS_SVH
`ifndef SYNTH
`define ZCPD_CHECK(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("zcpd check failed");
`define ZCPD_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zcpd sequence check failed");
`else
`define ZCPD_CHECK(label, expr)
`define ZCPD_CHECK_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/zcpd_pkg.sv =====
`default_nettype none

package zcpd_pkg;

    localparam int DEF_COUNTER_BITS = 20;
    localparam int DEF_SAMPLE_BITS  = 24;

    localparam int FREQ_BITS     = 22;
    localparam int RATE_BITS     = 18;
    localparam int MINP_BITS     = 20;
    localparam int Q_FRAC_BITS   = 4;
    localparam int CFG_DATA_BITS = 22;
    localparam int CFG_IDX_BITS  = 2;
    localparam int QCNT_BITS     = $clog2(FREQ_BITS);

    localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_RATE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOW_FREQ    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_PERIOD  = 2'd3;

    localparam logic [RATE_BITS-1:0] RST_SAMPLE_RATE = 18'd48000;
    localparam logic [FREQ_BITS-1:0] RST_LOW_FREQ    = '0;
    localparam logic [MINP_BITS-1:0] RST_MIN_PERIOD  = 20'd3;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // input transfer this cycle
        logic start;    // accepted item is a crossing, load divider
        logic step;     // one quotient bit
        logic finish;   // form estimate, load result
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic crossing; // current input is an accepted crossing
        logic out_busy; // result register full and stalled
    } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/zcpd_ctrl.sv =====
`default_nettype none

`include "zero_crossing_pitch_detector_top_macros.svh"

module zcpd_ctrl
    import zcpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [QCNT_BITS-1:0]  qcnt_reg, qcnt_next;

    assign in_stall = (state_reg != ST_IDLE) || status.out_busy;

    always_comb
    begin
        state_next = state_reg;
        qcnt_next  = qcnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid && !in_stall;
                if (cmd.accept && status.crossing)
                begin
                    cmd.start  = 1'b1;
                    qcnt_next  = QCNT_BITS'(FREQ_BITS - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.step  = 1'b1;
                qcnt_next = qcnt_reg - 1'b1;
                if (qcnt_reg == '0)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold the estimate until the result register is free
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            qcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            qcnt_reg  <= qcnt_next;
        end
    end

    `ZCPD_CHECK_NEXT(a_start_enters_div, cmd.start, state_reg == ST_DIV)
    `ZCPD_CHECK_NEXT(a_last_step_to_fin, state_reg == ST_DIV && qcnt_reg == '0,
                     state_reg == ST_FIN)

endmodule

`default_nettype wire

// ===== sv/zcpd_datapath.sv =====
`default_nettype none

`include "zero_crossing_pitch_detector_top_macros.svh"

module zcpd_datapath
    import zcpd_pkg::*;
#(
    parameter int COUNTER_BITS = DEF_COUNTER_BITS,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                       out_stall,
    output logic                            out_valid,
    output logic [FREQ_BITS-1:0]            frequency,
    output logic                            in_range,
    output logic                            detected,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]   cfg_data,
    input  wire dp_cmd_t                    cmd,
    output dp_status_t                      status
);

    localparam int DIV_BITS = COUNTER_BITS + 1;
    localparam int CMP_BITS = (COUNTER_BITS > MINP_BITS) ? COUNTER_BITS : MINP_BITS;

    // configuration
    logic                   enable_reg;
    logic [RATE_BITS-1:0]   rate_reg;
    logic [FREQ_BITS-1:0]   low_reg;
    logic [MINP_BITS-1:0]   minp_reg;

    // detector state
    logic                    prev_pos_reg;
    logic [COUNTER_BITS-1:0] count_reg;
    logic [COUNTER_BITS-1:0] hist_reg [3];
    logic [FREQ_BITS-1:0]    freq_reg;
    logic                    range_reg;

    // divider
    logic [FREQ_BITS-1:0]    quo_reg;
    logic [DIV_BITS-1:0]     rem_reg;
    logic [DIV_BITS-1:0]     div_reg;
    logic                    div_zero_reg;
    logic                    alt_reg;

    // result register
    logic                    out_valid_reg;
    logic [FREQ_BITS-1:0]    out_freq_reg;
    logic                    out_range_reg;
    logic                    out_det_reg;

    logic                    pos;
    logic [COUNTER_BITS-1:0] diff_h1;
    logic [COUNTER_BITS-1:0] diff_h0;
    logic                    alt;
    logic [DIV_BITS-1:0]     divisor;
    logic [DIV_BITS:0]       trial;
    logic                    trial_ge;
    logic [FREQ_BITS-1:0]    quo_final;
    logic [FREQ_BITS:0]      avg_sum;
    logic [FREQ_BITS-1:0]    est;
    logic                    est_hit;
    logic                    load_direct;

    assign pos = (sample != '0) && !sample[SAMPLE_BITS-1];

    assign status.crossing = enable_reg && pos && !prev_pos_reg &&
                             (CMP_BITS'(count_reg) >= CMP_BITS'(minp_reg));
    assign status.out_busy = out_valid_reg && out_stall;

    // new interval is count_reg; it becomes hist[0], old hist[0..1] move down
    assign diff_h1 = (count_reg >= hist_reg[1]) ? count_reg - hist_reg[1]
                                                : hist_reg[1] - count_reg;
    assign diff_h0 = (count_reg >= hist_reg[0]) ? count_reg - hist_reg[0]
                                                : hist_reg[0] - count_reg;
    assign alt     = (diff_h1 <= COUNTER_BITS'(1)) && (diff_h0 > COUNTER_BITS'(1));
    assign divisor = alt ? ({1'b0, count_reg} + {1'b0, hist_reg[0]})
                         : {1'b0, count_reg};

    // restoring divider, one quotient bit a cycle
    assign trial    = {rem_reg, quo_reg[FREQ_BITS-1]};
    assign trial_ge = trial >= {1'b0, div_reg};

    assign quo_final = div_zero_reg ? '0 : quo_reg;
    assign avg_sum   = {1'b0, freq_reg} + {1'b0, quo_final};
    assign est       = alt_reg ? quo_final : avg_sum[FREQ_BITS:1];
    assign est_hit   = est > low_reg;

    assign load_direct = cmd.accept && !cmd.start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            rate_reg   <= RST_SAMPLE_RATE;
            low_reg    <= RST_LOW_FREQ;
            minp_reg   <= RST_MIN_PERIOD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE:      enable_reg <= cfg_data[0];
                REG_SAMPLE_RATE: rate_reg   <= cfg_data[RATE_BITS-1:0];
                REG_LOW_FREQ:    low_reg    <= cfg_data[FREQ_BITS-1:0];
                REG_MIN_PERIOD:  minp_reg   <= cfg_data[MINP_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pos_reg <= 1'b1;
            count_reg    <= '0;
            hist_reg[0]  <= '0;
            hist_reg[1]  <= '0;
            hist_reg[2]  <= '0;
            freq_reg     <= '0;
            range_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.accept && enable_reg)
            begin
                prev_pos_reg <= pos;
                if (cmd.start)
                    count_reg <= COUNTER_BITS'(1);
                else if (count_reg != '1)
                    count_reg <= count_reg + 1'b1;
            end
            if (cmd.start)
            begin
                hist_reg[0] <= count_reg;
                hist_reg[1] <= hist_reg[0];
                hist_reg[2] <= hist_reg[1];
            end
            if (cmd.finish)
            begin
                freq_reg  <= est_hit ? est : '0;
                range_reg <= est_hit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            quo_reg      <= {rate_reg, Q_FRAC_BITS'(0)};
            rem_reg      <= '0;
            div_reg      <= divisor;
            div_zero_reg <= (divisor == '0);
            alt_reg      <= alt;
        end
        else if (cmd.step)
        begin
            quo_reg <= {quo_reg[FREQ_BITS-2:0], trial_ge};
            rem_reg <= trial_ge ? DIV_BITS'(trial - {1'b0, div_reg})
                                : trial[DIV_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_direct || cmd.finish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_direct)
        begin
            out_freq_reg  <= enable_reg ? freq_reg : '0;
            out_range_reg <= enable_reg && range_reg;
            out_det_reg   <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_freq_reg  <= est_hit ? est : '0;
            out_range_reg <= est_hit;
            out_det_reg   <= est_hit;
        end
    end

    assign out_valid = out_valid_reg;
    assign frequency = out_freq_reg;
    assign in_range  = out_range_reg;
    assign detected  = out_det_reg;

    `ZCPD_CHECK(a_det_has_range, !(out_valid_reg && out_det_reg) || out_range_reg)
    `ZCPD_CHECK(a_no_overwrite, !((load_direct || cmd.finish) && status.out_busy))

endmodule

`default_nettype wire

// ===== sv/zero_crossing_pitch_detector_top.sv =====
`default_nettype none

// Zero-crossing pitch detector: one signed sample per input transfer, one
// result (frequency in unsigned Q.4 Hz, in_range, detected) per sample.
// A sample that is not an accepted positive-going crossing has its result
// in the output register on the next cycle. An accepted crossing runs a
// restoring divider for 16*sample_rate over the interval (or over the sum
// of the last two intervals when they alternate); that takes the accepting
// transfer, the divider steps in ST_DIV and a finish step in ST_FIN, which
// waits while the output register is stalled, with in_stall high in ST_DIV
// and ST_FIN. in_stall is also high while a result waits in the output
// register under out_stall. Configuration writes take effect at the next
// edge and must only be issued while the block is idle.

module zero_crossing_pitch_detector_top
    import zcpd_pkg::*;
#(
    parameter int COUNTER_BITS = DEF_COUNTER_BITS,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [FREQ_BITS-1:0]               frequency,
    output logic                               in_range,
    output logic                               detected,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]      cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    zcpd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    zcpd_datapath
    #(
        .COUNTER_BITS (COUNTER_BITS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .frequency (frequency),
        .in_range  (in_range),
        .detected  (detected),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// ===== tb/zero_crossing_pitch_detector_top_test.sv =====
`default_nettype none

module zero_crossing_pitch_detector_top_test
    import zcpd_pkg::*;
();

    localparam int COUNTER_W    = DEF_COUNTER_BITS;
    localparam int SAMPLE_W     = DEF_SAMPLE_BITS;
    localparam int SETTLE       = 26;      // divider latency plus margin
    localparam int QUIET_LIMIT  = 2000;
    localparam logic [63:0] FREQ_MASK = (64'd1 << FREQ_BITS) - 64'd1;
    localparam logic [SAMPLE_W-1:0] MAX_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] MIN_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic [FREQ_BITS-1:0] frequency;
        logic                 in_range;
        logic                 detected;
    } pitch_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic out_valid;
    logic out_stall;
    logic [FREQ_BITS-1:0] frequency;
    logic in_range;
    logic detected;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // register mirror
    logic                 cfg_enable;
    logic [RATE_BITS-1:0] cfg_rate;
    logic [FREQ_BITS-1:0] cfg_low_freq;
    logic [MINP_BITS-1:0] cfg_min_period;

    // tracker state
    logic                 was_positive;
    logic [COUNTER_W-1:0] run_length;
    logic [COUNTER_W-1:0] period_hist [3];
    logic [FREQ_BITS-1:0] pitch_q4;
    logic                 pitch_valid;

    pitch_result_t pending_results[$];
    pitch_result_t oldest;

    bit send_gaps   = 1'b1;
    bit recv_stalls = 1'b1;
    int fail_count    = 0;
    int samples_sent  = 0;
    int results_seen  = 0;
    int detect_count  = 0;
    int settings_used = 0;

    zero_crossing_pitch_detector_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .frequency (frequency),
        .in_range  (in_range),
        .detected  (detected),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] q4_rate_over(logic [63:0] n);
        if (n == 64'd0)
            return 64'd0;
        return ((64'(cfg_rate) << Q_FRAC_BITS) / n) & FREQ_MASK;
    endfunction

    function automatic logic [63:0] gap_between(logic [63:0] a, logic [63:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic void reset_tracker();
        cfg_enable     = 1'b1;
        cfg_rate       = RST_SAMPLE_RATE;
        cfg_low_freq   = RST_LOW_FREQ;
        cfg_min_period = RST_MIN_PERIOD;
        was_positive   = 1'b1;
        run_length     = '0;
        period_hist[0] = '0;
        period_hist[1] = '0;
        period_hist[2] = '0;
        pitch_q4       = '0;
        pitch_valid    = 1'b0;
    endfunction

    function automatic pitch_result_t track_pitch(logic [SAMPLE_W-1:0] s);
        pitch_result_t r;
        logic          positive;
        logic          alternating;
        logic [63:0]   cand;
        logic [63:0]   est;
        logic [63:0]   sum;
        r = '0;
        positive = (s != '0) && !s[SAMPLE_W-1];
        if (!cfg_enable)
            return r;
        if (positive && !was_positive && run_length >= cfg_min_period)
        begin
            cand = q4_rate_over(64'(run_length));
            period_hist[2] = period_hist[1];
            period_hist[1] = period_hist[0];
            period_hist[0] = run_length;
            alternating = gap_between(period_hist[0], period_hist[2]) <= 64'd1 &&
                          gap_between(period_hist[0], period_hist[1]) > 64'd1;
            if (alternating)
            begin
                sum = 64'(period_hist[0]) + 64'(period_hist[1]);
                est = (sum != 64'd0) ? q4_rate_over(sum) : cand;
            end
            else
            begin
                est = ((64'(pitch_q4) + cand) >> 1) & FREQ_MASK;
            end
            if (est > 64'(cfg_low_freq))
            begin
                pitch_q4    = est[FREQ_BITS-1:0];
                pitch_valid = 1'b1;
                r.detected  = 1'b1;
            end
            else
            begin
                pitch_q4    = '0;
                pitch_valid = 1'b0;
            end
            run_length = '0;
        end
        if (run_length != '1)
            run_length = run_length + 1'b1;
        was_positive = positive;
        r.frequency = pitch_q4;
        r.in_range  = pitch_valid;
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] positive_sample();
        return {1'b0, (SAMPLE_W-1)'($urandom_range(1, 32'(MAX_POS)))};
    endfunction

    function automatic logic [SAMPLE_W-1:0] nonpositive_sample();
        if ($urandom_range(0, 3) == 0)
            return '0;
        return {1'b1, (SAMPLE_W-1)'($urandom)};
    endfunction

    task automatic send_sample(logic [SAMPLE_W-1:0] s);
        int gap;
        gap = send_gaps ? $urandom_range(0, 15) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(track_pitch(s));
        if (pending_results[$].detected)
            detect_count++;
        samples_sent++;
    endtask

    // one waveform cycle: crossing on the first positive, interval = len
    task automatic send_period(int len);
        int highs;
        highs = $urandom_range(1, len - 1);
        repeat (highs) send_sample(positive_sample());
        repeat (len - highs) send_sample(nonpositive_sample());
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ENABLE:      cfg_enable     = data[0];
            REG_SAMPLE_RATE: cfg_rate       = data[RATE_BITS-1:0];
            REG_LOW_FREQ:    cfg_low_freq   = data[FREQ_BITS-1:0];
            REG_MIN_PERIOD:  cfg_min_period = data[MINP_BITS-1:0];
            default: ;
        endcase
    endtask

    // junk above each register's width must be ignored
    task automatic apply_settings(logic en, logic [RATE_BITS-1:0] rate,
                                  logic [FREQ_BITS-1:0] low, logic [MINP_BITS-1:0] minp);
        logic [31:0] junk;
        junk = $urandom;
        wait_for_results();
        write_reg(REG_ENABLE, CFG_DATA_BITS'({junk, en}));
        write_reg(REG_SAMPLE_RATE, CFG_DATA_BITS'({junk, rate}));
        write_reg(REG_LOW_FREQ, low);
        write_reg(REG_MIN_PERIOD, CFG_DATA_BITS'({junk, minp}));
        settings_used++;
    endtask

    task automatic send_waveform(int budget);
        int sent;
        int shape;
        int base;
        int other;
        int reps;
        int len;
        bit alternate;
        bit high_run;
        sent = 0;
        while (sent < budget)
        begin
            shape = $urandom_range(0, 9);
            if (shape < 7)
            begin
                base      = $urandom_range(2, 24);
                other     = base + $urandom_range(2, 6);
                alternate = (shape < 3);
                reps      = $urandom_range(2, 6);
                for (int r = 0; r < reps; r++)
                begin
                    if (alternate)
                        len = r[0] ? other : base;
                    else
                        len = base - 1 + $urandom_range(0, 2);
                    if (len < 2)
                        len = 2;
                    send_period(len);
                    sent += len;
                end
            end
            else if (shape < 9)
            begin
                len = $urandom_range(1, 12);
                repeat (len) send_sample(SAMPLE_W'($urandom));
                sent += len;
            end
            else
            begin
                // broken waveform: a long run of one sign
                len = $urandom_range(10, 60);
                high_run = 1'($urandom_range(0, 1));
                repeat (len)
                    send_sample(high_run ? positive_sample() : nonpositive_sample());
                sent += len;
            end
        end
    endtask

    task automatic test_reset_state_and_extremes();
        logic [SAMPLE_W-1:0] seq [10];
        seq = '{MAX_POS, MIN_NEG, '0, SAMPLE_W'(1), '1, '0, '0, MAX_POS, MIN_NEG,
                SAMPLE_W'(1)};
        foreach (seq[i])
            send_sample(seq[i]);
    endtask

    task automatic test_alternating_intervals();
        send_period(3);
        send_period(6);
        send_period(3);
        send_period(6);
    endtask

    task automatic test_register_corners();
        // zero rate: every divider quotient is zero
        apply_settings(1'b1, '0, '0, 20'd2);
        send_period(4);
        send_period(4);
        // slowest rate with no minimum period
        apply_settings(1'b1, RATE_BITS'(1), '0, '0);
        repeat (3) send_period(2);
        // fastest rate against the top threshold
        apply_settings(1'b1, RATE_BITS'(192000), FREQ_BITS'(3072000), MINP_BITS'(1));
        repeat (3) send_period(2);
    endtask

    task automatic test_disabled_freeze();
        apply_settings(1'b1, RATE_BITS'(44100), '0, 20'd3);
        send_period(5);
        wait_for_results();
        write_reg(REG_ENABLE, {{(CFG_DATA_BITS-1){1'b1}}, 1'b0});
        send_period(3);
        send_sample(MAX_POS);
        send_sample(MIN_NEG);
        wait_for_results();
        write_reg(REG_ENABLE, CFG_DATA_BITS'(1));
        send_period(5);
        send_period(5);
    endtask

    // crossings before the minimum period are ignored, back to back
    task automatic test_long_min_period();
        apply_settings(1'b1, RATE_BITS'(192000), '0, MINP_BITS'(40));
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        repeat (2)
        begin
            send_sample(MAX_POS);
            repeat (24) send_sample('0);
        end
        send_sample(MAX_POS);
        send_sample('0);
        wait_for_results();
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [RATE_BITS-1:0] rate;
        for (int phase = 0; phase < 6; phase++)
        begin
            rate = RATE_BITS'($urandom_range(1, 192000));
            case (phase)
                0: apply_settings(1'b1, rate, '0, MINP_BITS'($urandom_range(0, 8)));
                1: apply_settings(1'b1, RATE_BITS'(192000),
                                  FREQ_BITS'($urandom_range(0, 16 * 192000 / 10)), 20'd2);
                2: apply_settings(1'b1, RATE_BITS'(1), '0, '0);
                3: apply_settings(1'b1, rate, FREQ_BITS'(3072000),
                                  MINP_BITS'($urandom_range(0, 20)));
                default: apply_settings(1'b1, rate,
                                        FREQ_BITS'($urandom_range(0, 16 * int'(rate) / 8)),
                                        MINP_BITS'($urandom_range(0, 12)));
            endcase
            send_gaps   = (phase != 1);
            recv_stalls = (phase != 1) && (phase != 5);
            send_waveform(15);
            if (phase == 4)
            begin
                // hold off until the block has drained, then freeze it a while
                wait_for_results();
                write_reg(REG_ENABLE, CFG_DATA_BITS'(0));
                send_waveform(10);
                wait_for_results();
                write_reg(REG_ENABLE, CFG_DATA_BITS'(1));
            end
            send_waveform(15);
        end
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
    endtask

    // result side: random stall before each transfer
    initial
    begin : result_sink
        int hold;
        out_stall = 1'b0;
        forever
        begin
            hold = recv_stalls ? $urandom_range(0, 15) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: frequency %0d in_range %0b detected %0b",
                       frequency, in_range, detected);
                fail_count++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (frequency !== oldest.frequency)
                begin
                    $error("frequency: expected %0d, got %0d", oldest.frequency, frequency);
                    fail_count++;
                end
                if (in_range !== oldest.in_range)
                begin
                    $error("in_range: expected %0b, got %0b", oldest.in_range, in_range);
                    fail_count++;
                end
                if (detected !== oldest.detected)
                begin
                    $error("detected: expected %0b, got %0b", oldest.detected, detected);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("[zero_crossing_pitch_detector_top] ERROR");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        sample    = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_ENABLE;
        cfg_data  = '0;
        reset_tracker();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state_and_extremes();
        test_alternating_intervals();
        test_register_corners();
        test_disabled_freeze();
        test_long_min_period();
        test_random_traffic();
        wait_for_results();

        $display("Sent %0d samples over %0d register settings; %0d results compared,",
                 samples_sent, settings_used + 1, results_seen);
        $display("%0d of them new in-range pitch estimates.", detect_count);
        if (fail_count == 0)
            $display("[zero_crossing_pitch_detector_top] OK");
        else
            $display("[zero_crossing_pitch_detector_top] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== zero_crossing_pitch_detector_top.f =====
+incdir+sv
sv/zcpd_pkg.sv
sv/zcpd_ctrl.sv
sv/zcpd_datapath.sv
sv/zero_crossing_pitch_detector_top.sv
tb/zero_crossing_pitch_detector_top_test.sv
